FILE: hdl/fft16_pkg.sv
`default_nettype none
package fft16_pkg;
  localparam int unsigned SampleWidth = 16;
  localparam int unsigned TwiddleWidth = 16;
  localparam int unsigned QueueDepth = 2;
  localparam longint CosPi4Q30 = 64'sd759250125;
  localparam longint CosPi8Q30 = 64'sd992008094;
  localparam longint SinPi8Q30 = 64'sd410903207;

  typedef enum logic [1:0] {
    BackIdle,
    BackBfly,
    BackEmit
  } back_state_e;

  function automatic longint tw_const(longint q30, int unsigned tw);
    longint frac;
    frac = longint'(tw) - 1;
    return (q30 + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

  function automatic logic [3:0] bitrev4(logic [3:0] v);
    return {v[0], v[1], v[2], v[3]};
  endfunction
endpackage
`default_nettype wire

FILE: hdl/fft16_front.sv
`default_nettype none
module fft16_front #(
  parameter int unsigned SAMPLE_WIDTH = fft16_pkg::SampleWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] im_i,
  output logic                                q_valid_o,
  input  wire logic                           q_stall_i,
  output logic [3:0]                          q_slot_o,
  output logic signed [SAMPLE_WIDTH-1:0]      q_re_o,
  output logic signed [SAMPLE_WIDTH-1:0]      q_im_o,
  output logic                                q_end_o
);
  import fft16_pkg::*;
  // front: stamps each sample with its slot and frame-end flag, short queue to back
  logic [3:0] fill_q, fill_d;
  logic [QueueDepth-1:0] vld_q, vld_d;
  logic [3:0] slot_q [QueueDepth];
  logic signed [SAMPLE_WIDTH-1:0] re_q [QueueDepth];
  logic signed [SAMPLE_WIDTH-1:0] im_q [QueueDepth];
  logic acc, pop, to_upper;

  assign stall_o = vld_q[QueueDepth-1] && !pop;
  assign acc = valid_i && !stall_o;
  assign pop = vld_q[0] && !q_stall_i;
  assign to_upper = pop ? vld_q[1] : vld_q[0];
  assign fill_d = acc ? fill_q + 4'd1 : fill_q;
  assign q_valid_o = vld_q[0];
  assign q_slot_o = slot_q[0];
  assign q_re_o = re_q[0];
  assign q_im_o = im_q[0];
  assign q_end_o = slot_q[0] == 4'd15;

  always_comb begin
    vld_d = vld_q;
    if (pop) begin
      vld_d = {1'b0, vld_q[QueueDepth-1:1]};
    end
    if (acc) begin
      if (to_upper) begin
        vld_d[1] = 1'b1;
      end else begin
        vld_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      vld_q <= '0;
    end else begin
      fill_q <= fill_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && !to_upper) begin
      slot_q[0] <= fill_q;
      re_q[0] <= re_i;
      im_q[0] <= im_i;
    end else if (pop) begin
      slot_q[0] <= slot_q[1];
      re_q[0] <= re_q[1];
      im_q[0] <= im_q[1];
    end
    if (acc && to_upper) begin
      slot_q[1] <= fill_q;
      re_q[1] <= re_i;
      im_q[1] <= im_i;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/fft16_back.sv
`default_nettype none
module fft16_back #(
  parameter int unsigned SAMPLE_WIDTH = fft16_pkg::SampleWidth,
  parameter int unsigned TWIDDLE_WIDTH = fft16_pkg::TwiddleWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           q_valid_i,
  output logic                                q_stall_o,
  input  wire logic [3:0]                     q_slot_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] q_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] q_im_i,
  input  wire logic                           q_end_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic [3:0]                          bin_index_o,
  output logic signed [SAMPLE_WIDTH+5:0]      bin_re_o,
  output logic signed [SAMPLE_WIDTH+5:0]      bin_im_o,
  output logic                                last_bin_o
);
  import fft16_pkg::*;
  localparam int unsigned BW = SAMPLE_WIDTH + 6;
  localparam int unsigned TF = TWIDDLE_WIDTH - 1;
  localparam int unsigned PW = BW + TWIDDLE_WIDTH + 1;
  localparam logic signed [TWIDDLE_WIDTH:0] C4 =
    (TWIDDLE_WIDTH+1)'(tw_const(CosPi4Q30, TWIDDLE_WIDTH));
  localparam logic signed [TWIDDLE_WIDTH:0] C8 =
    (TWIDDLE_WIDTH+1)'(tw_const(CosPi8Q30, TWIDDLE_WIDTH));
  localparam logic signed [TWIDDLE_WIDTH:0] S8 =
    (TWIDDLE_WIDTH+1)'(tw_const(SinPi8Q30, TWIDDLE_WIDTH));
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (TF - 1);

  back_state_e state_q, state_d;
  logic signed [BW-1:0] xr_q [16];
  logic signed [BW-1:0] xi_q [16];
  logic [1:0] stg_q, stg_d;
  logic [2:0] bf_q, bf_d;
  logic [1:0] ph_q, ph_d;
  logic [3:0] cnt_q, cnt_d;
  logic ovld_q;
  logic [3:0] oidx_q;
  logic signed [BW-1:0] ore_q, oim_q;
  logic signed [BW-1:0] pr_q, pi_q;
  logic signed [PW-1:0] m0_q, m1_q, m2_q, m3_q;
  logic load, obusy;
  logic [3:0] h, kk, ia, ib;
  logic [2:0] tw;
  logic signed [BW-1:0] br, bi, ar, ai, yr, yi;
  logic signed [BW-1:0] sum, dif;
  logic signed [TWIDDLE_WIDTH:0] wr, wi;
  logic signed [BW-1:0] mx0, mx1;
  logic signed [TWIDDLE_WIDTH:0] mw0, mw1, mw2, mw3;
  logic signed [PW-1:0] p0, p1, p2, p3;

  function automatic logic signed [BW-1:0] rnd(logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HALF) >>> TF;
    return t[BW-1:0];
  endfunction

  assign obusy = ovld_q && stall_i;
  assign load = q_valid_i && state_q == BackIdle;
  assign q_stall_o = state_q != BackIdle;

  assign h = 4'd1 << stg_q;
  assign kk = {1'b0, bf_q} & (h - 4'd1);
  assign ia = (({1'b0, bf_q} - kk) << 1) + kk;
  assign ib = ia + h;
  assign tw = 3'(kk << (2'd3 - stg_q));
  assign ar = xr_q[ia];
  assign ai = xi_q[ia];
  assign br = xr_q[ib];
  assign bi = xi_q[ib];
  assign sum = BW'(br + bi);
  assign dif = BW'(bi - br);

  always_comb begin
    wr = C8;
    wi = -S8;
    mx0 = br;
    mx1 = bi;
    unique case (tw)
      3'd1: begin wr = C8; wi = -S8; end
      3'd3: begin wr = S8; wi = -C8; end
      3'd5: begin wr = -S8; wi = -C8; end
      3'd7: begin wr = -C8; wi = -S8; end
      3'd2, 3'd6: begin mx0 = sum; mx1 = dif; end
      default: ;
    endcase
    mw0 = wr;
    mw1 = wi;
    mw2 = wi;
    mw3 = wr;
    if (tw == 3'd2) begin
      mw0 = C4; mw1 = C4; mw2 = C4; mw3 = C4;
    end else if (tw == 3'd6) begin
      mw0 = -C4; mw1 = C4; mw2 = -C4; mw3 = C4;
    end
  end

  assign p0 = PW'(mx0) * PW'(mw0);
  assign p1 = PW'(mx1) * PW'(mw1);
  assign p2 = PW'(mx0) * PW'(mw2);
  assign p3 = PW'(mx1) * PW'(mw3);

  always_comb begin
    unique case (tw)
      3'd0: begin yr = br; yi = bi; end
      3'd4: begin yr = bi; yi = -br; end
      3'd2: begin yr = rnd(m0_q); yi = rnd(m1_q); end
      3'd6: begin yr = rnd(m1_q); yi = rnd(m0_q); end
      default: begin
        yr = rnd(m0_q) - rnd(m1_q);
        yi = rnd(m2_q) + rnd(m3_q);
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    stg_d = stg_q;
    bf_d = bf_q;
    ph_d = ph_q;
    cnt_d = cnt_q;
    unique case (state_q)
      BackIdle: if (load && q_end_i) begin
        state_d = BackBfly;
        stg_d = '0;
        bf_d = '0;
        ph_d = '0;
      end
      BackBfly: begin
        ph_d = ph_q + 2'd1;
        if (ph_q == 2'd1) begin
          ph_d = '0;
          bf_d = bf_q + 3'd1;
          if (bf_q == 3'd7) begin
            stg_d = stg_q + 2'd1;
            if (stg_q == 2'd3) begin
              state_d = BackEmit;
              cnt_d = '0;
            end
          end
        end
      end
      BackEmit: if (!obusy) begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          state_d = BackIdle;
        end
      end
      default: state_d = BackIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BackIdle;
      stg_q <= '0;
      bf_q <= '0;
      ph_q <= '0;
      cnt_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stg_q <= stg_d;
      bf_q <= bf_d;
      ph_q <= ph_d;
      cnt_q <= cnt_d;
      if (state_q == BackEmit && !obusy) begin
        ovld_q <= 1'b1;
      end else if (!stall_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      xr_q[bitrev4(q_slot_i)] <= BW'(q_re_i);
      xi_q[bitrev4(q_slot_i)] <= BW'(q_im_i);
    end
    if (state_q == BackBfly && ph_q == 2'd0) begin
      m0_q <= p0;
      m1_q <= p1;
      m2_q <= p2;
      m3_q <= p3;
      pr_q <= ar;
      pi_q <= ai;
    end
    if (state_q == BackBfly && ph_q == 2'd1) begin
      xr_q[ia] <= pr_q + yr;
      xi_q[ia] <= pi_q + yi;
      xr_q[ib] <= pr_q - yr;
      xi_q[ib] <= pi_q - yi;
    end
    if (state_q == BackEmit && !obusy) begin
      oidx_q <= cnt_q;
      ore_q <= xr_q[cnt_q];
      oim_q <= xi_q[cnt_q];
    end
  end

  assign valid_o = ovld_q;
  assign bin_index_o = oidx_q;
  assign bin_re_o = ore_q;
  assign bin_im_o = oim_q;
  assign last_bin_o = oidx_q == 4'd15;
endmodule
`default_nettype wire

FILE: hdl/fft16_complex_unit.sv
`default_nettype none
// 16-point forward complex fft, radix-2 decimation in time. samples enter in natural order;
// after the 16th sample the bins leave in natural order, last_bin_o on bin 15. a front queue
// takes samples at one per cycle while it has room; one shared butterfly unit does 32 butterflies,
// each registering its twiddle products and then writing back sum and difference, then 16 emits.
// samples of the next frame wait in the queue until the emit pass finishes.
module fft16_complex_unit #(
  parameter int unsigned SAMPLE_WIDTH = fft16_pkg::SampleWidth,
  parameter int unsigned TWIDDLE_WIDTH = fft16_pkg::TwiddleWidth
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  output logic                                stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_im_i,
  output logic                                valid_o,
  input  wire logic                           stall_i,
  output logic [3:0]                          bin_index_o,
  output logic signed [SAMPLE_WIDTH+5:0]      bin_re_o,
  output logic signed [SAMPLE_WIDTH+5:0]      bin_im_o,
  output logic                                last_bin_o
);
  logic qv, qs, qe;
  logic [3:0] qslot;
  logic signed [SAMPLE_WIDTH-1:0] qre, qim;

  fft16_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o,
    .re_i(sample_re_i), .im_i(sample_im_i),
    .q_valid_o(qv), .q_stall_i(qs), .q_slot_o(qslot),
    .q_re_o(qre), .q_im_o(qim), .q_end_o(qe)
  );

  fft16_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .TWIDDLE_WIDTH(TWIDDLE_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_stall_o(qs), .q_slot_i(qslot),
    .q_re_i(qre), .q_im_i(qim), .q_end_i(qe),
    .valid_o, .stall_i, .bin_index_o, .bin_re_o, .bin_im_o, .last_bin_o
  );
endmodule
`default_nettype wire

FILE: hdl/fft16_checker.sv
`default_nettype none
module fft16_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_o,
  input wire logic       stall_i,
  input wire logic [3:0] bin_index_o,
  input wire logic       last_bin_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(bin_index_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> last_bin_o == (bin_index_o == 4'd15))
    else $error("last flag off bin 15");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !stall_i && !last_bin_o |=> valid_o && bin_index_o == $past(bin_index_o) + 4'd1)
    else $error("bins out of order");
endmodule

bind fft16_complex_unit fft16_checker u_chk (
  .clk_i, .rst_ni, .valid_o, .stall_i, .bin_index_o, .last_bin_o
);
`default_nettype wire

FILE: verif/fft16_complex_unit_test.sv
`timescale 1ns / 1ps
module fft16_complex_unit_test;
  import fft16_pkg::*;

  localparam int unsigned SW = SampleWidth;
  localparam int unsigned BW = SampleWidth + 6;
  localparam int unsigned FRAC = TwiddleWidth - 1;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic signed [SW-1:0] re;
    logic signed [SW-1:0] im;
  } sample_t;

  typedef struct {
    logic [3:0]           idx;
    logic signed [BW-1:0] re;
    logic signed [BW-1:0] im;
    logic                 last;
  } bin_t;

  typedef struct {
    longint re;
    longint im;
  } cplx_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_o;
  logic signed [SW-1:0] sample_re_i = '0;
  logic signed [SW-1:0] sample_im_i = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [3:0] bin_index_o;
  logic signed [BW-1:0] bin_re_o;
  logic signed [BW-1:0] bin_im_o;
  logic last_bin_o;

  // stall as seen at the last rising edge: tells the driver whether the transaction went
  logic stall_q = 1'b1;

  fft16_complex_unit u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(valid_i),
    .stall_o(stall_o),
    .sample_re_i(sample_re_i),
    .sample_im_i(sample_im_i),
    .valid_o(valid_o),
    .stall_i(stall_i),
    .bin_index_o(bin_index_o),
    .bin_re_o(bin_re_o),
    .bin_im_o(bin_im_o),
    .last_bin_o(last_bin_o)
  );

  always #10 clk_i = ~clk_i;

  sample_t pending_samples[$];
  bin_t expected_bins[$];
  sample_t frame_buf[16];
  int unsigned fill_slot = 0;
  int unsigned samples_sent = 0;
  int unsigned bins_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  bit quiet = 1'b0;
  bit hold_sender = 1'b0;
  bit timed_out = 1'b0;
  longint cos4, cos8, sin8;

  function automatic longint round_q(longint p);
    return (p + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic cplx_t rotate(cplx_t x, int unsigned t);
    cplx_t y;
    longint wr, wi;
    y = x;
    wr = 0;
    wi = 0;
    case (t)
      0: ;
      4: begin
        y.re = x.im;
        y.im = -x.re;
      end
      2: begin
        y.re = round_q(cos4 * (x.re + x.im));
        y.im = round_q(cos4 * (x.im - x.re));
      end
      6: begin
        y.re = round_q(cos4 * (x.im - x.re));
        y.im = round_q(-cos4 * (x.re + x.im));
      end
      default: begin
        if (t == 1) begin
          wr = cos8;
          wi = -sin8;
        end else if (t == 3) begin
          wr = sin8;
          wi = -cos8;
        end else if (t == 5) begin
          wr = -sin8;
          wi = -cos8;
        end else begin
          wr = -cos8;
          wi = -sin8;
        end
        y.re = round_q(x.re * wr) - round_q(x.im * wi);
        y.im = round_q(x.re * wi) + round_q(x.im * wr);
      end
    endcase
    return y;
  endfunction

  // bit-reversed load, four radix-2 stages
  task automatic transform_frame();
    cplx_t x[16];
    cplx_t a, b;
    int unsigned r;
    bin_t e;
    for (int i = 0; i < 16; i++) begin
      r = {i[0], i[1], i[2], i[3]};
      x[i].re = frame_buf[r].re;
      x[i].im = frame_buf[r].im;
    end
    for (int h = 1; h < 16; h = h * 2) begin
      for (int base = 0; base < 16; base += 2 * h) begin
        for (int k = 0; k < h; k++) begin
          a = x[base + k];
          b = rotate(x[base + k + h], k * (8 / h));
          x[base + k].re = a.re + b.re;
          x[base + k].im = a.im + b.im;
          x[base + k + h].re = a.re - b.re;
          x[base + k + h].im = a.im - b.im;
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      e.idx = i[3:0];
      e.re = x[i].re[BW-1:0];
      e.im = x[i].im[BW-1:0];
      e.last = (i == 15);
      expected_bins.push_back(e);
    end
  endtask

  task automatic queue_frame(int unsigned kind);
    sample_t s;
    for (int n = 0; n < 16; n++) begin
      case (kind)
        0: begin
          s.re = 16'sh7fff;
          s.im = 16'sh7fff;
        end
        1: begin
          s.re = 16'sh8000;
          s.im = 16'sh8000;
        end
        2: begin
          s.re = n[0] ? 16'sh8000 : 16'sh7fff;
          s.im = n[0] ? 16'sh7fff : 16'sh8000;
        end
        3: begin
          s.re = (n == 0) ? 16'sh7fff : '0;
          s.im = (n == 1) ? 16'sh8000 : '0;
        end
        4: begin
          s.re = 16'($urandom_range(0, 1) ? 16'sh8000 + $urandom_range(0, 3) :
                                             16'sh7fff - $urandom_range(0, 3));
          s.im = 16'($urandom);
        end
        default: begin
          s.re = 16'($urandom);
          s.im = 16'($urandom);
        end
      endcase
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    cos4 = tw_const(CosPi4Q30, TwiddleWidth);
    cos8 = tw_const(CosPi8Q30, TwiddleWidth);
    sin8 = tw_const(SinPi8Q30, TwiddleWidth);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    queue_frame(3);
    for (int f = 0; f < 4; f++) queue_frame(4);
    wait (pending_samples.size() == 0 && !valid_i && expected_bins.size() == 0);
    hold_sender = 1'b1;
    repeat (40) @(posedge clk_i);
    hold_sender = 1'b0;
    queue_frame(0);
    queue_frame(1);
    queue_frame(2);
    for (int f = 0; f < 6; f++) queue_frame(5);
    quiet = 1'b1;
    for (int f = 0; f < 4; f++) queue_frame(5);
    wait (pending_samples.size() == 0 && !valid_i && expected_bins.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d samples in %0d frames, %0d bins checked", samples_sent,
             samples_sent / 16, bins_seen);
    $display("extreme, impulse and random frames, with idling on both sides");
    if (mismatches == 0 && expected_bins.size() == 0 && !timed_out) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || !stall_q) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          valid_i <= 1'b0;
        end else if (!hold_sender && pending_samples.size() > 0) begin
          valid_i <= 1'b1;
          sample_re_i <= pending_samples[0].re;
          sample_im_i <= pending_samples[0].im;
          pending_samples.pop_front();
          if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 10);
        end else begin
          valid_i <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        recv_gap <= $urandom_range(0, 9);
        stall_i <= 1'b1;
      end else begin
        stall_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    bin_t e;
    stall_q <= stall_o;
    if (rst_ni) begin
      if (valid_i && !stall_o) begin
        frame_buf[fill_slot] = '{re: sample_re_i, im: sample_im_i};
        samples_sent++;
        if (fill_slot == 15) begin
          fill_slot = 0;
          transform_frame();
        end else begin
          fill_slot++;
        end
      end
      if (valid_o && !stall_i) begin
        bins_seen++;
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected bin %0d", bin_index_o);
        end else begin
          e = expected_bins.pop_front();
          if (bin_index_o !== e.idx || bin_re_o !== e.re || bin_im_o !== e.im ||
              last_bin_o !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bin mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d", e.idx,
                       e.re, e.im, e.last, bin_index_o, bin_re_o, bin_im_o, last_bin_o);
          end
        end
      end
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end
endmodule

FILE: fft16_complex_unit.f
hdl/fft16_pkg.sv
hdl/fft16_front.sv
hdl/fft16_back.sv
hdl/fft16_complex_unit.sv
hdl/fft16_checker.sv
verif/fft16_complex_unit_test.sv
